>>> src/spsc_pkg.sv
// ----------------------------------------------------------------------------
// spsc_pkg
// Shared types and codes of the single page swap controller.
// ----------------------------------------------------------------------------
`default_nettype none

package spsc_pkg;

    // result kinds
    localparam logic [1:0] KIND_MAP  = 2'd0;
    localparam logic [1:0] KIND_COPY = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_REGION_BASE   = 2'd0;
    localparam logic [1:0] CFG_SHADOW_OFFSET = 2'd1;
    localparam logic [1:0] CFG_RAM_BASE      = 2'd2;

    // reset values of the configuration registers
    localparam logic [15:0] RST_REGION_BASE   = 16'd17408;
    localparam logic [15:0] RST_SHADOW_OFFSET = 16'd8192;
    localparam logic [15:0] RST_RAM_BASE      = 16'd7168;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RANGE,
        S_MUL,
        S_CORR,
        S_CHECK,
        S_SAVE,
        S_FILL,
        S_MAP,
        S_SCAN,
        S_DONE
    } t_state;

    // which result the datapath loads into the output register
    typedef enum logic [2:0] {
        EM_NONE,
        EM_SAVE,
        EM_FILL,
        EM_MAP,
        EM_SCAN,
        EM_DONE
    } t_emit;

    typedef struct packed {
        logic  load_in;
        logic  calc_range;
        logic  calc_mul;
        logic  calc_corr;
        t_emit emit;
        logic  scan_clr;
        logic  scan_inc;
    } t_cmd;

    typedef struct packed {
        logic in_region;
        logic miss;
        logic slot_free;
        logic scan_mark;
        logic scan_last;
    } t_stat;

endpackage

`default_nettype wire

>>> src/spsc_ctrl.sv
// ----------------------------------------------------------------------------
// spsc_ctrl
// Sequencer: divides the access into range, multiply and correct steps, then
// issues the result transactions of a hit, a miss or a commit walk.
// ----------------------------------------------------------------------------
`default_nettype none

module spsc_ctrl
    import spsc_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    input  wire   i_op,
    output logic  o_in_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_op ? S_SCAN : S_RANGE;
                end
            end
            S_RANGE: n_state = S_MUL;
            S_MUL:   n_state = S_CORR;
            S_CORR:  n_state = S_CHECK;
            S_CHECK: begin
                if (i_stat.in_region && i_stat.miss) begin
                    n_state = S_SAVE;
                end else begin
                    n_state = S_MAP;
                end
            end
            S_SAVE: begin
                if (i_stat.slot_free) n_state = S_FILL;
            end
            S_FILL: begin
                if (i_stat.slot_free) n_state = S_MAP;
            end
            S_MAP: begin
                if (i_stat.slot_free) n_state = S_IDLE;
            end
            S_SCAN: begin
                if ((!i_stat.scan_mark || i_stat.slot_free) && i_stat.scan_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.slot_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '{load_in: 1'b0, calc_range: 1'b0, calc_mul: 1'b0, calc_corr: 1'b0,
                  emit: EM_NONE, scan_clr: 1'b0, scan_inc: 1'b0};
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load_in  = i_in_valid;
                o_cmd.scan_clr = i_in_valid;
            end
            S_RANGE: o_cmd.calc_range = 1'b1;
            S_MUL:   o_cmd.calc_mul   = 1'b1;
            S_CORR:  o_cmd.calc_corr  = 1'b1;
            S_CHECK: ;
            S_SAVE:  o_cmd.emit = i_stat.slot_free ? EM_SAVE : EM_NONE;
            S_FILL:  o_cmd.emit = i_stat.slot_free ? EM_FILL : EM_NONE;
            S_MAP:   o_cmd.emit = i_stat.slot_free ? EM_MAP : EM_NONE;
            S_SCAN: begin
                if (i_stat.scan_mark) begin
                    o_cmd.emit     = i_stat.slot_free ? EM_SCAN : EM_NONE;
                    o_cmd.scan_inc = i_stat.slot_free;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                end
            end
            S_DONE:  o_cmd.emit = i_stat.slot_free ? EM_DONE : EM_NONE;
            default: ;
        endcase
    end

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state != S_IDLE))
        else $error("accepted transaction did not start work");

    a_map_waits_for_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAP && !i_stat.slot_free) |=> (r_state == S_MAP))
        else $error("final result dropped while output register was busy");

endmodule

`default_nettype wire

>>> src/spsc_datapath.sv
// ----------------------------------------------------------------------------
// spsc_datapath
// Configuration registers, page arithmetic, page marks and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module spsc_datapath
    import spsc_pkg::*;
#(
    parameter int NUM_PAGES  = 8,
    parameter int PAGE_BYTES = 1024
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_idx,
    input  wire  [15:0] i_cfg_data,
    input  wire  [15:0] i_addr,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [1:0]  o_kind,
    output logic [15:0] o_copy_src,
    output logic [15:0] o_copy_dst,
    output logic [15:0] o_mapped_addr,
    output logic        o_last
);

    localparam int PW = $clog2(NUM_PAGES);
    localparam int OW = $clog2(PAGE_BYTES);
    // floor(2^16 / PAGE_BYTES): quotient estimate is exact or one low
    localparam int RECIP = 65536 / PAGE_BYTES;
    localparam logic [19:0] SPAN20 = 20'(NUM_PAGES * PAGE_BYTES);
    localparam logic [15:0] PB16   = 16'(PAGE_BYTES);
    localparam logic [PW-1:0] LAST_PAGE = PW'(NUM_PAGES - 1);

    logic [15:0]          r_base, r_shoff, r_ram;
    logic [15:0]          r_addr, r_diff;
    logic                 r_in_region;
    logic [PW-1:0]        r_q0, r_page, r_cur_page, r_scan;
    logic [OW-1:0]        r_off;
    logic [NUM_PAGES-1:0] r_marks;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= RST_REGION_BASE;
            r_shoff <= RST_SHADOW_OFFSET;
            r_ram   <= RST_RAM_BASE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_REGION_BASE:   r_base  <= i_cfg_data;
                CFG_SHADOW_OFFSET: r_shoff <= i_cfg_data;
                CFG_RAM_BASE:      r_ram   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // page arithmetic
    logic [15:0] diff;
    logic [31:0] prod;
    logic [15:0] qpb, rem;
    logic        rem_ge;

    assign diff   = r_addr - r_base;
    assign prod   = 32'(r_diff) * 32'(RECIP);
    assign qpb    = 16'(32'(r_q0) * 32'(PAGE_BYTES));
    assign rem    = r_diff - qpb;
    assign rem_ge = (rem >= PB16);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) r_addr <= i_addr;
        if (i_cmd.calc_range) begin
            r_diff      <= diff;
            r_in_region <= (r_addr >= r_base) && ({4'b0, diff} < SPAN20);
        end
        if (i_cmd.calc_mul) r_q0 <= prod[16 +: PW];
        if (i_cmd.calc_corr) begin
            r_page <= rem_ge ? r_q0 + PW'(1) : r_q0;
            r_off  <= rem_ge ? OW'(rem - PB16) : OW'(rem);
        end
    end

    // home address of the page picked by the pending result
    logic [PW-1:0] hp;
    logic [15:0]   home, shadow;

    always_comb begin
        case (i_cmd.emit)
            EM_SAVE: hp = r_cur_page;
            EM_FILL: hp = r_page;
            default: hp = r_scan;
        endcase
    end

    assign home   = r_base + 16'(32'(hp) * 32'(PAGE_BYTES));
    assign shadow = home + r_shoff;

    // page state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_page <= '0;
            r_marks    <= '0;
            r_scan     <= '0;
        end else begin
            if (i_cmd.emit == EM_SAVE) r_marks[r_cur_page] <= 1'b1;
            if (i_cmd.emit == EM_FILL) r_cur_page <= r_page;
            if (i_cmd.scan_clr) begin
                r_scan <= '0;
            end else if (i_cmd.scan_inc && r_scan != LAST_PAGE) begin
                r_scan <= r_scan + PW'(1);
            end
        end
    end

    // output register
    logic slot_free;
    assign slot_free = !o_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit != EM_NONE) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.emit)
            EM_SAVE: begin
                o_kind <= KIND_COPY; o_copy_src <= r_ram; o_copy_dst <= shadow;
                o_mapped_addr <= '0; o_last <= 1'b0;
            end
            EM_FILL: begin
                o_kind <= KIND_COPY;
                o_copy_src <= r_marks[r_page] ? shadow : home;
                o_copy_dst <= r_ram; o_mapped_addr <= '0; o_last <= 1'b0;
            end
            EM_MAP: begin
                o_kind <= KIND_MAP; o_copy_src <= '0; o_copy_dst <= '0;
                o_mapped_addr <= r_in_region ? r_ram + 16'(r_off) : r_addr;
                o_last <= 1'b1;
            end
            EM_SCAN: begin
                o_kind <= KIND_COPY; o_copy_src <= shadow; o_copy_dst <= home;
                o_mapped_addr <= '0; o_last <= 1'b0;
            end
            EM_DONE: begin
                o_kind <= KIND_DONE; o_copy_src <= '0; o_copy_dst <= '0;
                o_mapped_addr <= '0; o_last <= 1'b1;
            end
            default: ;
        endcase
    end

    assign o_stat = '{in_region: r_in_region,
                      miss:      (r_page != r_cur_page),
                      slot_free: slot_free,
                      scan_mark: r_marks[r_scan],
                      scan_last: (r_scan == LAST_PAGE)};

    a_emit_into_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit != EM_NONE) |-> (!o_out_valid || !i_out_stall))
        else $error("result loaded over a stalled transaction");

    a_save_marks_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit == EM_SAVE) |=> r_marks[$past(r_cur_page)])
        else $error("saved page not marked as held in shadow");

endmodule

`default_nettype wire

>>> src/single_page_swap_controller.sv
// ----------------------------------------------------------------------------
// single_page_swap_controller
// Pages a nonvolatile region through one RAM page buffer: translates access
// addresses, emits save/fill copy commands on a page miss, and walks the
// shadow marks on a commit.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                fields
//  -------  ---------  -----------------------  ----------------------------------
//  in       sink       i_in_valid / o_in_stall  i_op, i_addr
//  out      source     o_out_valid / i_out_stall o_kind, o_copy_src, o_copy_dst,
//                                               o_mapped_addr, o_last
//  cfg      sink       i_cfg_we                 i_cfg_idx, i_cfg_data
//
//  Access transaction: the range / reciprocal-multiply / correct steps of the
//  page divide, a check, save and fill copies on an in-region miss, then the map.
//  Commit: one page mark checked per cycle; a marked page waits for a free slot.
//  One transaction is worked at a time; the next is taken while the last
//  result still sits in the output register.
//  Synchronous active-low reset: page 0 current, all marks cleared, config
//  registers back to their defaults. Output stalls hold the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module single_page_swap_controller
    import spsc_pkg::*;
#(
    parameter int NUM_PAGES  = 8,
    parameter int PAGE_BYTES = 1024
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // configuration
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_idx,
    input  wire  [15:0] i_cfg_data,
    // request channel
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire         i_op,
    input  wire  [15:0] i_addr,
    // result channel
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [1:0]  o_kind,
    output logic [15:0] o_copy_src,
    output logic [15:0] o_copy_dst,
    output logic [15:0] o_mapped_addr,
    output logic        o_last
);

    t_cmd  cmd;
    t_stat stat;

    // sequencer
    spsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // address math, page marks, output register
    spsc_datapath #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_addr        (i_addr),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_kind        (o_kind),
        .o_copy_src    (o_copy_src),
        .o_copy_dst    (o_copy_dst),
        .o_mapped_addr (o_mapped_addr),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for single_page_swap_controller.
// Sends access and commit transactions with random gaps and output stalls,
// keeps its own copy of the page and shadow-mark state to predict every
// result, and checks results in order, field by field.
// ----------------------------------------------------------------------------
module tb;
    import spsc_pkg::*;

    localparam int NUM_PAGES   = 8;
    localparam int PAGE_BYTES  = 1024;
    localparam int REGION_SPAN = NUM_PAGES * PAGE_BYTES;
    localparam int CYCLE_LIMIT = 300000;   // watchdog bound on the whole run
    localparam int LONG_HOLD   = 250;      // receiver hold-off, in cycles
    localparam int MAX_PRINTS  = 40;       // mismatch lines printed, rest counted
    localparam int PHASE_ITEMS = 41;

    // request opcodes
    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_COMMIT = 1'b1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] src;
        logic [15:0] dst;
        logic [15:0] mapped;
        logic        last;
    } t_swap_result;

    // ------------------------------------------------------------------------
    // Page swap scoreboard: mirrors registers, current page and shadow marks,
    // and queues the results each accepted request must produce.
    // ------------------------------------------------------------------------
    class swap_scoreboard;
        logic [15:0]  region_base;
        logic [15:0]  shadow_offset;
        logic [15:0]  ram_base;
        int unsigned  cur_page;
        bit           marks [NUM_PAGES];
        t_swap_result pending [$];
        int errors, n_requests, n_results, n_misses, n_commits;

        function new();
            region_base   = RST_REGION_BASE;
            shadow_offset = RST_SHADOW_OFFSET;
            ram_base      = RST_RAM_BASE;
            cur_page      = 0;
            foreach (marks[p]) marks[p] = 1'b0;
            errors = 0; n_requests = 0; n_results = 0; n_misses = 0; n_commits = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] data);
            case (idx)
                CFG_REGION_BASE:   region_base   = data;
                CFG_SHADOW_OFFSET: shadow_offset = data;
                CFG_RAM_BASE:      ram_base      = data;
                default: ;
            endcase
        endfunction

        // home address of a page, wraps at 64K
        function logic [15:0] page_home(int unsigned page);
            page_home = region_base + 16'(page * PAGE_BYTES);
        endfunction

        function void add(logic [1:0] kind, logic [15:0] src, logic [15:0] dst,
                          logic [15:0] mapped);
            t_swap_result r;
            r.kind = kind; r.src = src; r.dst = dst; r.mapped = mapped; r.last = 1'b0;
            pending.push_back(r);
        endfunction

        function void note_request(logic op, logic [15:0] addr);
            int unsigned delta, page, offs;
            n_requests++;
            if (op == OP_COMMIT) begin
                n_commits++;
                for (int unsigned p = 0; p < NUM_PAGES; p++)
                    if (marks[p])
                        add(KIND_COPY, page_home(p) + shadow_offset, page_home(p), '0);
                add(KIND_DONE, '0, '0, '0);
            end else begin
                // unsigned distance: below the base it is huge, so half-open
                // membership reduces to a single compare
                delta = 32'(addr) - 32'(region_base);
                if (delta >= REGION_SPAN) begin
                    add(KIND_MAP, '0, '0, addr);
                end else begin
                    page = delta / PAGE_BYTES;
                    offs = delta % PAGE_BYTES;
                    if (page != cur_page) begin
                        n_misses++;
                        add(KIND_COPY, ram_base, page_home(cur_page) + shadow_offset, '0);
                        marks[cur_page] = 1'b1;
                        if (marks[page])
                            add(KIND_COPY, page_home(page) + shadow_offset, ram_base, '0);
                        else
                            add(KIND_COPY, page_home(page), ram_base, '0);
                        cur_page = page;
                    end
                    add(KIND_MAP, '0, '0, ram_base + 16'(offs));
                end
            end
            pending[pending.size() - 1].last = 1'b1;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_result(t_swap_result got);
            t_swap_result want;
            n_results++;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result kind=%0d src=%h dst=%h map=%h",
                                 got.kind, got.src, got.dst, got.mapped));
                return;
            end
            want = pending.pop_front();
            if (got.kind != want.kind)
                report($sformatf("kind got %0d want %0d", got.kind, want.kind));
            if (got.src != want.src)
                report($sformatf("copy_src got %h want %h", got.src, want.src));
            if (got.dst != want.dst)
                report($sformatf("copy_dst got %h want %h", got.dst, want.dst));
            if (got.mapped != want.mapped)
                report($sformatf("mapped_addr got %h want %h", got.mapped, want.mapped));
            if (got.last != want.last)
                report($sformatf("last got %0b want %0b", got.last, want.last));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT signals, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_idx   = CFG_REGION_BASE;
    logic [15:0] i_cfg_data  = '0;
    logic        i_in_valid  = 1'b0;
    logic        i_op        = OP_ACCESS;
    logic [15:0] i_addr      = '0;
    logic        i_out_stall = 1'b0;
    wire         o_in_stall;
    wire         o_out_valid;
    wire  [1:0]  o_kind;
    wire  [15:0] o_copy_src;
    wire  [15:0] o_copy_dst;
    wire  [15:0] o_mapped_addr;
    wire         o_last;

    swap_scoreboard sb;

    // idle control, shared between the stimulus and the receiver
    bit send_idle     = 1'b1;
    bit recv_idle     = 1'b1;
    int hold_requests = 0;   // bumped by the stimulus to ask for a long hold-off
    int hold_seen     = 0;
    int hold_left     = 0;
    int stall_left    = 0;
    int cycles        = 0;

    single_page_swap_controller #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_addr        (i_addr),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_kind        (o_kind),
        .o_copy_src    (o_copy_src),
        .o_copy_dst    (o_copy_dst),
        .o_mapped_addr (o_mapped_addr),
        .o_last        (o_last)
    );

    always #5 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[%0t] timeout after %0d cycles", $time, cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result monitor: samples at the rising edge, before the DUT updates.
    // Each accepted result draws the stall that precedes the next one.
    always @(posedge i_clk) begin
        t_swap_result got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.kind   = o_kind;
            got.src    = o_copy_src;
            got.dst    = o_copy_dst;
            got.mapped = o_mapped_addr;
            got.last   = o_last;
            sb.check_result(got);
            stall_left = recv_idle ? $urandom_range(0, 8) : 0;
        end
    end

    // Receiver stall driver. A long hold-off request wins over the
    // per-transaction stall; only one assignment per falling edge.
    always @(negedge i_clk) begin
        if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------------

    // Offer one request; valid stays high across back-to-back transactions.
    task automatic send_item(input logic op, input logic [15:0] addr);
        int gap;
        gap = send_idle ? $urandom_range(0, 8) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_addr     <= addr;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(op, addr);
    endtask

    // Stop offering and wait until every predicted result is back.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        // last result out means the sequencer is back in idle; small margin
        repeat (4) @(negedge i_clk);
    endtask

    // Write all three registers on consecutive cycles (block is idle).
    task automatic configure(input logic [15:0] base, input logic [15:0] shadow,
                             input logic [15:0] ram);
        logic [1:0]  idx  [3];
        logic [15:0] data [3];
        idx[0] = CFG_REGION_BASE;   data[0] = base;
        idx[1] = CFG_SHADOW_OFFSET; data[1] = shadow;
        idx[2] = CFG_RAM_BASE;      data[2] = ram;
        for (int k = 0; k < 3; k++) begin
            @(negedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx[k];
            i_cfg_data <= data[k];
            sb.set_reg(idx[k], data[k]);
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly well-formed page traffic: stays on the current page or jumps
    // to another one, with commits mixed in; the rest is boundary probes and
    // arbitrary addresses.
    task automatic random_item();
        int unsigned sel, page, offs;
        logic [15:0] base;
        base = sb.region_base;
        sel  = $urandom_range(0, 99);
        if (sel < 12) begin
            send_item(OP_COMMIT, 16'($urandom));
        end else if (sel < 80) begin
            page = ($urandom_range(0, 9) < 4) ? sb.cur_page : $urandom_range(0, NUM_PAGES - 1);
            case ($urandom_range(0, 9))
                0:       offs = 0;
                1:       offs = PAGE_BYTES - 1;
                default: offs = $urandom_range(0, PAGE_BYTES - 1);
            endcase
            send_item(OP_ACCESS, base + 16'(page * PAGE_BYTES + offs));
        end else if (sel < 88) begin
            // just outside either end of the region
            send_item(OP_ACCESS, $urandom_range(0, 1) ? base - 16'd1
                                                     : base + 16'(REGION_SPAN));
        end else begin
            send_item(OP_ACCESS, 16'($urandom));
        end
    endtask

    task automatic run_phase(input logic [15:0] base, input logic [15:0] shadow,
                             input logic [15:0] ram, input bit gaps, input bit hold);
        drain();
        configure(base, shadow, ram);
        send_idle = gaps;
        recv_idle = gaps;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            // long receiver hold-off while requests keep coming, so the
            // block backs up and stalls its input
            if (hold && n == 4)
                hold_requests++;
            random_item();
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        sb = new();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset registers, page 0 current, no marks
        send_item(OP_COMMIT, 16'h0000);                            // commit, nothing marked
        send_item(OP_ACCESS, 16'h0000);                            // below region
        send_item(OP_ACCESS, 16'hFFFF);                            // above region
        send_item(OP_ACCESS, RST_REGION_BASE - 16'd1);             // one below base
        send_item(OP_ACCESS, RST_REGION_BASE);                     // hit, first byte
        send_item(OP_ACCESS, RST_REGION_BASE + 16'(PAGE_BYTES - 1));   // hit, last byte
        send_item(OP_ACCESS, RST_REGION_BASE + 16'(PAGE_BYTES));   // miss, fill from home
        send_item(OP_ACCESS, RST_REGION_BASE + 16'(REGION_SPAN - 1));  // last page
        send_item(OP_ACCESS, RST_REGION_BASE + 16'(REGION_SPAN));  // end is exclusive
        send_item(OP_ACCESS, RST_REGION_BASE + 16'd5);             // miss, fill from shadow
        send_item(OP_COMMIT, 16'hFFFF);
        // visit every page so all marks get set, then a full commit
        for (int p = 1; p < NUM_PAGES; p++)
            send_item(OP_ACCESS, RST_REGION_BASE +
                      16'(p * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1)));
        send_item(OP_ACCESS, RST_REGION_BASE + 16'(3 * PAGE_BYTES));
        send_item(OP_COMMIT, 16'($urandom));                       // eight copies + done

        // region running past 64K: commit home addresses wrap
        drain();
        configure(16'hF000, 16'h1000, 16'hFC00);
        send_item(OP_COMMIT, 16'h5A5A);
        send_item(OP_ACCESS, 16'hFFFF);
        send_item(OP_ACCESS, 16'hF000);

        // random phases over several register settings, extremes included
        run_phase(RST_REGION_BASE, RST_SHADOW_OFFSET, RST_RAM_BASE, 1'b1, 1'b1);
        run_phase(16'hF000, 16'($urandom), 16'($urandom), 1'b0, 1'b0);
        run_phase(16'h0000, 16'hFFFF, 16'h0000, 1'b1, 1'b0);
        run_phase(16'hFFFF, 16'h0000, 16'hFFFF, 1'b1, 1'b0);
        run_phase(16'($urandom), 16'($urandom), 16'($urandom), 1'b1, 1'b0);
        run_phase(16'($urandom_range(0, 16'hDFFF)), 16'($urandom), 16'($urandom),
                  1'b1, 1'b1);

        drain();
        repeat (20) @(negedge i_clk);
        if (sb.pending.size() != 0)
            sb.report($sformatf("%0d expected results never arrived", sb.pending.size()));

        $display("Run covered %0d requests (%0d commits, %0d page misses), %0d results,",
                 sb.n_requests, sb.n_commits, sb.n_misses, sb.n_results);
        $display("eight register settings, random gaps and stalls, two long output hold-offs.");
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
